>>> design/battery_level_monitor_defines.svh
// Assertion macros shared by the battery level monitor RTL.
`ifndef BATTERY_LEVEL_MONITOR_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> design/blm_pkg.sv
// Package with types, constants and register codes of the battery level monitor.
`default_nettype none
package blm_pkg;

	// Field widths.
	localparam int DATA_W    = 12;
	localparam int SUM_W     = 16;
	localparam int LOW_CNT_W = 8;
	localparam int BAR_W     = 2;
	localparam int REG_IDX_W = 3;

	// Parameter defaults.
	localparam int SAMPLES_DEF        = 10;
	localparam int DIFF_MIN_DEF       = 0;
	localparam int SHUTDOWN_COUNT_DEF = 3;

	// Windows buffered between the accumulator and the evaluation pipeline.
	localparam int QUEUE_DEPTH = 2;

	// Fraction bits of the reciprocal used for the constant divide.
	localparam int RECIP_K = 20;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ADC_LOW        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ADC_HIGH       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIFF_HIGH      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHUTDOWN_LEVEL = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BATT_BAR_LOW   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BATT_BAR_HIGH  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CHG_BAR_LOW    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_CHG_BAR_HIGH   = 3'd7;

	// Register reset values.
	localparam logic [DATA_W-1:0] ADC_LOW_RST   = 12'd0;
	localparam logic [DATA_W-1:0] ADC_HIGH_RST  = 12'd4095;
	localparam logic [DATA_W-1:0] DIFF_HIGH_RST = 12'd30;
	localparam logic [DATA_W-1:0] SHUT_LVL_RST  = 12'd0;
	localparam logic [DATA_W-1:0] BAR_LOW_RST   = 12'd0;
	localparam logic [DATA_W-1:0] BAR_HIGH_RST  = 12'd4095;

	// Bar level codes.
	localparam logic [BAR_W-1:0] BAR_NONE = 2'd0;
	localparam logic [BAR_W-1:0] BAR_LOW  = 2'd1;
	localparam logic [BAR_W-1:0] BAR_MID  = 2'd2;
	localparam logic [BAR_W-1:0] BAR_HIGH = 2'd3;

	// Configuration register set.
	typedef struct packed {
		logic [DATA_W-1:0] adc_low;
		logic [DATA_W-1:0] adc_high;
		logic [DATA_W-1:0] diff_high;
		logic [DATA_W-1:0] shutdown_level;
		logic [DATA_W-1:0] batt_bar_low;
		logic [DATA_W-1:0] batt_bar_high;
		logic [DATA_W-1:0] chg_bar_low;
		logic [DATA_W-1:0] chg_bar_high;
	} cfg_t;

	// One completed window, as handed from the accumulator to the evaluator.
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [DATA_W-1:0] min;
		logic [DATA_W-1:0] max;
		logic              charging;
		logic              alarm_enable;
	} win_t;

	// Three-step level from a mean and two thresholds.
	function automatic logic [BAR_W-1:0] bar_of(input logic [DATA_W-1:0] m,
			input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		logic [BAR_W-1:0] b;
		if (m <= lo) begin
			b = BAR_LOW;
		end else if (m <= hi) begin
			b = BAR_MID;
		end else begin
			b = BAR_HIGH;
		end
		return b;
	endfunction

endpackage
`default_nettype wire

>>> design/blm_front.sv
// Sample accumulator: running sum, minimum and maximum over one window.
`default_nettype none
`include "battery_level_monitor_defines.svh"
module blm_front import blm_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DATA_W-1:0] sample,
	input  wire logic              charging,
	input  wire logic              alarm_enable,
	input  wire logic              q_full,
	output logic                   push,
	output win_t                   push_win
);

	localparam int CNT_W = $clog2(SAMPLES + 1);

	logic [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0] min_q;
	logic [DATA_W-1:0] max_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              accept;
	logic [SUM_W-1:0]  sum_next;
	logic [DATA_W-1:0] min_next;
	logic [DATA_W-1:0] max_next;
	logic [CNT_W-1:0]  cnt_next;
	logic              win_done;

	// An item is taken whenever the queue has room for a finished window.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Window statistics including the current item.
	always_comb begin
		sum_next = sum_q + SUM_W'(sample);
		min_next = (sample < min_q) ? sample : min_q;
		max_next = (sample > max_q) ? sample : max_q;
		cnt_next = cnt_q + 1'b1;
		win_done = (cnt_next == CNT_W'(SAMPLES));
	end

	// Hand the finished window to the queue.
	assign push                  = accept && win_done;
	assign push_win.sum          = sum_next;
	assign push_win.min          = min_next;
	assign push_win.max          = max_next;
	assign push_win.charging     = charging;
	assign push_win.alarm_enable = alarm_enable;

	// Accumulate, restarting after the last item of a window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (win_done) begin
				sum_q <= '0;
				min_q <= '1;
				max_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				min_q <= min_next;
				max_q <= max_next;
				cnt_q <= cnt_next;
			end
		end
	end

	`BLM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q < CNT_W'(SAMPLES), "window count out of range")
	`BLM_ASSERT_NOW(a_min_le_max, cnt_q != '0, min_q <= max_q, "window minimum above maximum")

endmodule
`default_nettype wire

>>> design/blm_queue.sv
// Short queue of finished windows between the accumulator and the evaluator.
`default_nettype none
`include "battery_level_monitor_defines.svh"
module blm_queue import blm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  win_t      push_win,
	output logic      full,
	output logic      pop_valid,
	input  wire logic pop,
	output win_t      pop_win
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	win_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_win   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_win;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`BLM_ASSERT_NOW(a_no_overflow, push, !full, "window pushed into a full queue")

endmodule
`default_nettype wire

>>> design/blm_back.sv
// Window evaluator: trimmed mean, clamp, slot compare, level and shutdown count.
`default_nettype none
`include "battery_level_monitor_defines.svh"
module blm_back import blm_pkg::*; #(
	parameter int SAMPLES        = SAMPLES_DEF,
	parameter int DIFF_MIN       = DIFF_MIN_DEF,
	parameter int SHUTDOWN_COUNT = SHUTDOWN_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  wire logic              pop_valid,
	output logic                   pop,
	input  win_t                   pop_win,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      mean_level,
	output logic                   stable,
	output logic [BAR_W-1:0]       bar_level,
	output logic                   shutdown_request
);

	// Divide by the trimmed count through a reciprocal and one correction.
	localparam int DIV     = SAMPLES - 2;
	localparam int RECIP   = (1 << RECIP_K) / DIV;
	localparam int RECIP_W = RECIP_K + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	logic pipe_en;

	// Stage 1 registers.
	logic             v_s1;
	logic [SUM_W-1:0] trim_s1;
	logic [SUM_W-1:0] quot_s1;
	logic             chg_s1;
	logic             alarm_s1;

	// Stage 2 registers.
	logic              v_s2;
	logic [DATA_W-1:0] a_s2;
	logic [DATA_W-1:0] b_s2;
	logic              chg_s2;
	logic              alarm_s2;

	// Slot state.
	logic [DATA_W-1:0] slot_a_q;
	logic [DATA_W-1:0] slot_b_q;
	logic              slot_sel_q;
	logic [LOW_CNT_W-1:0] low_cnt_q;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] mean_q;
	logic              stable_q;
	logic [BAR_W-1:0]  bar_q;
	logic              req_q;

	logic [SUM_W-1:0]  trim;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  rem;
	logic [SUM_W-1:0]  avg;
	logic [DATA_W-1:0] avg_clamp;
	logic [DATA_W-1:0] a_next;
	logic [DATA_W-1:0] b_next;

	logic [DATA_W-1:0]    diff;
	logic [DATA_W:0]      pair_sum;
	logic [DATA_W-1:0]    m;
	logic                 in_band;
	logic                 in_range;
	logic                 cnt_up;
	logic [LOW_CNT_W-1:0] low_cnt_inc;
	logic [DATA_W-1:0]    mean_d;
	logic                 stable_d;
	logic [BAR_W-1:0]     bar_d;
	logic                 req_d;

	// The whole pipeline moves unless a result is waiting to be taken.
	assign pipe_en = !out_valid_q || out_ready;
	assign pop     = pipe_en && pop_valid;

	// Stage 1: drop the extremes and multiply by the reciprocal.
	always_comb begin
		trim = pop_win.sum - SUM_W'(pop_win.min) - SUM_W'(pop_win.max);
		prod = PROD_W'(trim) * PROD_W'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			trim_s1  <= trim;
			quot_s1  <= prod[RECIP_K +: SUM_W];
			chg_s1   <= pop_win.charging;
			alarm_s1 <= pop_win.alarm_enable;
		end
	end

	// Stage 2: correct the quotient, clamp it and place it in its slot.
	always_comb begin
		rem = trim_s1 - quot_s1 * SUM_W'(DIV);
		avg = quot_s1 + SUM_W'(rem >= SUM_W'(DIV));
		if (avg >= SUM_W'(cfg.adc_low) && avg <= SUM_W'(cfg.adc_high)) begin
			avg_clamp = avg[DATA_W-1:0];
		end else if (avg > SUM_W'(cfg.adc_high)) begin
			avg_clamp = cfg.adc_high;
		end else begin
			avg_clamp = cfg.adc_low;
		end
		a_next = slot_sel_q ? slot_a_q : avg_clamp;
		b_next = slot_sel_q ? avg_clamp : slot_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			slot_a_q   <= '0;
			slot_b_q   <= '0;
			slot_sel_q <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				slot_a_q   <= a_next;
				slot_b_q   <= b_next;
				slot_sel_q <= !slot_sel_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			a_s2     <= a_next;
			b_s2     <= b_next;
			chg_s2   <= chg_s1;
			alarm_s2 <= alarm_s1;
		end
	end

	// Stage 3: slot difference, mean, level and low-battery count.
	always_comb begin
		diff        = (a_s2 >= b_s2) ? a_s2 - b_s2 : b_s2 - a_s2;
		in_band     = (diff >= DATA_W'(DIFF_MIN)) && (diff <= cfg.diff_high);
		pair_sum    = {1'b0, a_s2} + {1'b0, b_s2};
		m           = pair_sum[DATA_W:1];
		in_range    = (m >= cfg.adc_low) && (m <= cfg.adc_high);
		low_cnt_inc = low_cnt_q + 1'b1;
		cnt_up      = 1'b0;
		mean_d      = '0;
		stable_d    = 1'b0;
		bar_d       = BAR_NONE;
		req_d       = 1'b0;
		if (in_band) begin
			if (in_range) begin
				stable_d = 1'b1;
				mean_d   = m;
				cnt_up   = alarm_s2 && !chg_s2 && (m < cfg.shutdown_level)
					&& (low_cnt_q != '1);
				req_d    = cnt_up && (low_cnt_inc == LOW_CNT_W'(SHUTDOWN_COUNT));
				bar_d    = chg_s2 ? bar_of(m, cfg.chg_bar_low, cfg.chg_bar_high)
					: bar_of(m, cfg.batt_bar_low, cfg.batt_bar_high);
			end else if (m > cfg.adc_high) begin
				stable_d = 1'b1;
				mean_d   = alarm_s2 ? cfg.adc_high : m;
			end else if (!alarm_s2) begin
				stable_d = 1'b1;
				mean_d   = m;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			low_cnt_q   <= '0;
		end else if (pipe_en) begin
			out_valid_q <= v_s2;
			if (v_s2 && cnt_up) begin
				low_cnt_q <= low_cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mean_q   <= mean_d;
			stable_q <= stable_d;
			bar_q    <= bar_d;
			req_q    <= req_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign mean_level       = mean_q;
	assign stable           = stable_q;
	assign bar_level        = bar_q;
	assign shutdown_request = req_q;

	`BLM_ASSERT_NOW(a_req_needs_level, out_valid_q && req_q,
		stable_q && (bar_q != BAR_NONE), "shutdown request without a shown level")
	`BLM_ASSERT_NEXT(a_low_cnt_mono, 1'b1, low_cnt_q >= $past(low_cnt_q),
		"low-battery count went down")

endmodule
`default_nettype wire

>>> design/battery_level_monitor.sv
// Top level of the battery level monitor: configuration registers and block wiring.
//
//   channel  direction  handshake                  payload
//   input    in         in_valid / in_ready        sample, charging, alarm_enable
//   output   out        out_valid / out_ready      mean_level, stable, bar_level,
//                                                  shutdown_request
//   config   in         cfg_write                  cfg_index, cfg_data
//
// One sample item is taken per cycle while the queue is not full; every
// SAMPLES-th item closes a window. A window's result passes through the queue,
// the divide stage, the clamp stage and the output register, one window per cycle at most.
// A two-window queue separates the accumulator from the evaluator; input stalls
// only when the queue is full because results are not being taken.
// Reset is asynchronous and clears all window, slot and counter state at once.
`default_nettype none
module battery_level_monitor import blm_pkg::*; #(
	parameter int SAMPLES        = SAMPLES_DEF,
	parameter int DIFF_MIN       = DIFF_MIN_DEF,
	parameter int SHUTDOWN_COUNT = SHUTDOWN_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [DATA_W-1:0]    sample,
	input  wire logic                 charging,
	input  wire logic                 alarm_enable,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [DATA_W-1:0]         mean_level,
	output logic                      stable,
	output logic [BAR_W-1:0]          bar_level,
	output logic                      shutdown_request
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	win_t push_win;
	logic pop_valid;
	logic pop;
	win_t pop_win;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_low        <= ADC_LOW_RST;
			cfg_q.adc_high       <= ADC_HIGH_RST;
			cfg_q.diff_high      <= DIFF_HIGH_RST;
			cfg_q.shutdown_level <= SHUT_LVL_RST;
			cfg_q.batt_bar_low   <= BAR_LOW_RST;
			cfg_q.batt_bar_high  <= BAR_HIGH_RST;
			cfg_q.chg_bar_low    <= BAR_LOW_RST;
			cfg_q.chg_bar_high   <= BAR_HIGH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ADC_LOW:        cfg_q.adc_low        <= cfg_data;
				REG_ADC_HIGH:       cfg_q.adc_high       <= cfg_data;
				REG_DIFF_HIGH:      cfg_q.diff_high      <= cfg_data;
				REG_SHUTDOWN_LEVEL: cfg_q.shutdown_level <= cfg_data;
				REG_BATT_BAR_LOW:   cfg_q.batt_bar_low   <= cfg_data;
				REG_BATT_BAR_HIGH:  cfg_q.batt_bar_high  <= cfg_data;
				REG_CHG_BAR_LOW:    cfg_q.chg_bar_low    <= cfg_data;
				REG_CHG_BAR_HIGH:   cfg_q.chg_bar_high   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Window accumulator.
	blm_front #(
		.SAMPLES(SAMPLES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.charging    (charging),
		.alarm_enable(alarm_enable),
		.q_full      (q_full),
		.push        (push),
		.push_win    (push_win)
	);

	// Queue of finished windows.
	blm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_win (push_win),
		.full     (q_full),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_win  (pop_win)
	);

	// Window evaluator.
	blm_back #(
		.SAMPLES       (SAMPLES),
		.DIFF_MIN      (DIFF_MIN),
		.SHUTDOWN_COUNT(SHUTDOWN_COUNT)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.pop_valid       (pop_valid),
		.pop             (pop),
		.pop_win         (pop_win),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mean_level      (mean_level),
		.stable          (stable),
		.bar_level       (bar_level),
		.shutdown_request(shutdown_request)
	);

endmodule
`default_nettype wire

>>> bench/battery_level_monitor_tb.sv
// Self-checking testbench for the battery level monitor: window stimulus, level predictor, checker.
`default_nettype none
module battery_level_monitor_tb;
	import blm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LEN   = SAMPLES_DEF;
	localparam int BAND_FLOOR   = DIFF_MIN_DEF;
	localparam int TRIP_COUNT   = SHUTDOWN_COUNT_DEF;
	localparam int PHASES       = 9;
	localparam int PHASE_WINS   = 6;
	localparam int SETTLE       = 8;
	localparam int DRAIN        = 20;
	localparam int LONG_HOLD    = 120;
	localparam int CYCLE_LIMIT  = 400000;

	// One window result as the block reports it.
	typedef struct packed {
		logic [DATA_W-1:0] mean_level;
		logic              stable;
		logic [BAR_W-1:0]  bar_level;
		logic              shutdown_request;
	} level_report_t;

	// One row of the opening table: a window built from a body value plus both extremes.
	typedef struct {
		logic [DATA_W-1:0] body;
		logic              charging;
		logic              alarm_enable;
		logic              typed;
		level_report_t     want;
	} window_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_ADC_LOW;
	logic [DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [DATA_W-1:0] sample = '0;
	logic charging = 1'b0;
	logic alarm_enable = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DATA_W-1:0] mean_level;
	logic stable;
	logic [BAR_W-1:0] bar_level;
	logic shutdown_request;

	// Predictor state: running window, the two held averages and the low-battery count.
	cfg_t regs_model = '{ADC_LOW_RST, ADC_HIGH_RST, DIFF_HIGH_RST, SHUT_LVL_RST,
		BAR_LOW_RST, BAR_HIGH_RST, BAR_LOW_RST, BAR_HIGH_RST};
	logic [SUM_W-1:0] run_sum = '0;
	logic [DATA_W-1:0] run_min = '1;
	logic [DATA_W-1:0] run_max = '0;
	logic [3:0] run_count = '0;
	logic [DATA_W-1:0] hold_a = '0;
	logic [DATA_W-1:0] hold_b = '0;
	logic fill_b = 1'b0;
	logic [LOW_CNT_W-1:0] trip_count = '0;

	level_report_t expected_reports[$];
	int reports_seen = 0;
	int fault_count = 0;
	int cycle_count = 0;

	battery_level_monitor #(
		.SAMPLES(WINDOW_LEN),
		.DIFF_MIN(BAND_FLOOR),
		.SHUTDOWN_COUNT(TRIP_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.charging(charging),
		.alarm_enable(alarm_enable),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_level(mean_level),
		.stable(stable),
		.bar_level(bar_level),
		.shutdown_request(shutdown_request)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit; a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Advance the window by one accepted item and queue the report a closed window produces.
	task automatic track_sample(input logic [DATA_W-1:0] s, input logic chg, input logic alm,
			input logic typed, input level_report_t want);
		logic [SUM_W-1:0] trimmed;
		logic [DATA_W-1:0] avg;
		logic [DATA_W-1:0] gap;
		logic [DATA_W:0] pair;
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		level_report_t r;
		run_sum = run_sum + s;
		if (s < run_min) run_min = s;
		if (s > run_max) run_max = s;
		run_count = run_count + 1'b1;
		if (run_count < WINDOW_LEN) return;

		// Trimmed average of the closed window, clamped to the ADC range.
		trimmed = run_sum - run_min - run_max;
		avg = DATA_W'(trimmed / (WINDOW_LEN - 2));
		run_sum = '0;
		run_min = '1;
		run_max = '0;
		run_count = '0;
		if (!(avg >= regs_model.adc_low && avg <= regs_model.adc_high)) begin
			avg = (avg > regs_model.adc_high) ? regs_model.adc_high : regs_model.adc_low;
		end
		if (fill_b) hold_b = avg; else hold_a = avg;
		fill_b = ~fill_b;

		// Compare the two held averages and grade their mean.
		r = '0;
		gap = (hold_a >= hold_b) ? hold_a - hold_b : hold_b - hold_a;
		if (gap >= BAND_FLOOR && gap <= regs_model.diff_high) begin
			pair = {1'b0, hold_a} + hold_b;
			m = pair[DATA_W:1];
			if (m >= regs_model.adc_low && m <= regs_model.adc_high) begin
				r.stable = 1'b1;
				r.mean_level = m;
				if (alm && !chg && m < regs_model.shutdown_level && trip_count != '1) begin
					trip_count = trip_count + 1'b1;
					if (trip_count == TRIP_COUNT) r.shutdown_request = 1'b1;
				end
				lo = chg ? regs_model.chg_bar_low : regs_model.batt_bar_low;
				hi = chg ? regs_model.chg_bar_high : regs_model.batt_bar_high;
				if (m <= lo) r.bar_level = BAR_LOW;
				else if (m <= hi) r.bar_level = BAR_MID;
				else r.bar_level = BAR_HIGH;
			end else if (m > regs_model.adc_high) begin
				r.stable = 1'b1;
				r.mean_level = alm ? regs_model.adc_high : m;
			end else if (!alm) begin
				r.stable = 1'b1;
				r.mean_level = m;
			end
		end
		expected_reports.push_back(typed ? want : r);
	endtask

	// Offer one item after an idle gap and wait until the block takes it.
	task automatic send_item(input logic [DATA_W-1:0] s, input logic chg, input logic alm,
			input int idle, input logic typed, input level_report_t want);
		if (idle > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample <= s;
		charging <= chg;
		alarm_enable <= alm;
		do @(posedge clk); while (!in_ready);
		track_sample(s, chg, alm, typed, want);
	endtask

	// Drop valid and let every outstanding report come back before touching registers.
	task automatic finish_phase();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Write the whole register set and mirror it in the predictor.
	task automatic load_settings(input cfg_t c);
		put_reg(REG_ADC_LOW, c.adc_low);
		put_reg(REG_ADC_HIGH, c.adc_high);
		put_reg(REG_DIFF_HIGH, c.diff_high);
		put_reg(REG_SHUTDOWN_LEVEL, c.shutdown_level);
		put_reg(REG_BATT_BAR_LOW, c.batt_bar_low);
		put_reg(REG_BATT_BAR_HIGH, c.batt_bar_high);
		put_reg(REG_CHG_BAR_LOW, c.chg_bar_low);
		put_reg(REG_CHG_BAR_HIGH, c.chg_bar_high);
		@(negedge clk);
		cfg_write <= 1'b0;
		regs_model = c;
	endtask

	// Register set for one phase: typical values, both extremes, an inverted range and
	// the widest and narrowest acceptance bands.
	task automatic draw_settings(input int phase, output cfg_t c);
		c.adc_low = DATA_W'($urandom_range(0, 600));
		c.adc_high = DATA_W'($urandom_range(3400, 4095));
		c.diff_high = DATA_W'($urandom_range(8, 300));
		c.shutdown_level = DATA_W'($urandom_range(500, 3500));
		c.batt_bar_low = DATA_W'($urandom_range(0, 4095));
		c.batt_bar_high = DATA_W'($urandom_range(0, 4095));
		c.chg_bar_low = DATA_W'($urandom_range(0, 4095));
		c.chg_bar_high = DATA_W'($urandom_range(0, 4095));
		case (phase)
			1: c = '0;
			2: c = '1;
			3: begin
				c.adc_low = DATA_W'($urandom_range(2048, 4095));
				c.adc_high = DATA_W'($urandom_range(0, 2047));
			end
			4: begin
				c.adc_low = '0;
				c.adc_high = '1;
				c.diff_high = '1;
				c.shutdown_level = '1;
			end
			5: c.diff_high = '0;
			default: ;
		endcase
	endtask

	// One window around a drifting level; some samples are wild, some windows pure noise.
	task automatic send_window(input int centre, input int spread, input bit no_gaps);
		int v;
		int idle;
		int pick;
		bit noisy;
		noisy = ($urandom_range(0, 7) == 0);
		for (int k = 0; k < WINDOW_LEN; k++) begin
			if (noisy || $urandom_range(0, 9) == 0) begin
				v = $urandom_range(0, 4095);
			end else begin
				v = centre + $urandom_range(0, 2 * spread) - spread;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
			end
			pick = $urandom_range(0, 99);
			if (no_gaps || pick < 60) idle = 0;
			else if (pick < 92) idle = $urandom_range(1, 3);
			else idle = $urandom_range(8, 30);
			send_item(v[DATA_W-1:0], $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0,
				idle, 1'b0, '0);
		end
	endtask

	// Result side: mostly ready in bursts, short and occasional long stalls, and two long
	// hold-offs that back the block up into its input.
	initial begin
		int stall_left;
		int burst_left;
		bit held_first;
		bit held_second;
		stall_left = 0;
		burst_left = 0;
		held_first = 1'b0;
		held_second = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_first && reports_seen >= 3) begin
				held_first = 1'b1;
				stall_left = LONG_HOLD;
				burst_left = 0;
			end else if (!held_second && reports_seen >= 33) begin
				held_second = 1'b1;
				stall_left = LONG_HOLD;
				burst_left = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (burst_left > 0) begin
				out_ready <= 1'b1;
				burst_left--;
			end else if ($urandom_range(0, 9) < 7) begin
				out_ready <= 1'b1;
				burst_left = $urandom_range(0, 19);
			end else begin
				out_ready <= 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
					: $urandom_range(0, 2);
			end
		end
	end

	task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		fault_count++;
	endtask

	// Compare every taken result with the oldest expected report.
	always @(posedge clk) begin
		level_report_t want;
		if (arst_n && out_valid && out_ready) begin
			reports_seen <= reports_seen + 1;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected item, mean_level %0d stable %0d bar_level %0d",
					$time, mean_level, stable, bar_level);
				fault_count++;
			end else begin
				want = expected_reports.pop_front();
				if (mean_level !== want.mean_level)
					flag_field("mean_level", want.mean_level, mean_level);
				if (stable !== want.stable)
					flag_field("stable", DATA_W'(want.stable), DATA_W'(stable));
				if (bar_level !== want.bar_level)
					flag_field("bar_level", DATA_W'(want.bar_level), DATA_W'(bar_level));
				if (shutdown_request !== want.shutdown_request)
					flag_field("shutdown_request", DATA_W'(want.shutdown_request),
						DATA_W'(shutdown_request));
			end
		end
	end

	// Stimulus: reset, the opening table, then phases of random windows under new settings.
	initial begin
		window_row_t opening_rows[3];
		cfg_t c;
		logic [DATA_W-1:0] s;
		int centre;
		int step;
		bit no_gaps;
		// After reset the first window faces an empty slot, so it cannot be stable.
		opening_rows[0] = '{12'd100, 1'b0, 1'b1, 1'b1, '{12'd0, 1'b0, BAR_NONE, 1'b0}};
		// Two close windows on battery give their mean at the middle level.
		opening_rows[1] = '{12'd110, 1'b0, 1'b1, 1'b1, '{12'd105, 1'b1, BAR_MID, 1'b0}};
		opening_rows[2] = '{12'd4095, 1'b1, 1'b0, 1'b0, '0};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Each opening window carries a full-scale and a zero sample that get trimmed away.
		foreach (opening_rows[i]) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				s = (k == 0) ? '1 : (k == 5) ? '0 : opening_rows[i].body;
				send_item(s, opening_rows[i].charging, opening_rows[i].alarm_enable, 0,
					opening_rows[i].typed, opening_rows[i].want);
			end
		end
		finish_phase();

		for (int p = 0; p < PHASES; p++) begin
			draw_settings(p, c);
			load_settings(c);
			centre = $urandom_range(0, 4094);
			no_gaps = (p % 3 == 0);
			for (int w = 0; w < PHASE_WINS; w++) begin
				send_window(centre, $urandom_range(0, 4), no_gaps);
				step = $urandom_range(0, 12);
				centre = centre + step - 6;
				if (centre < 0) centre = 0;
				if (centre > 4094) centre = 4094;
			end
			finish_phase();
		end

		repeat (DRAIN) @(posedge clk);
		if (fault_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
